// ===== hw/rtl/gn3_pkg.sv =====
`timescale 1ns / 1ps
// gn3_pkg: shared constants and types for the 3-D gradient noise sampler.
// No dependencies.

package gn3_pkg;

  localparam int TABLE_SIZE_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int COORD_W  = 24;
  localparam int BYTE_W   = 8;
  localparam int OUT_W    = 16;
  localparam int OUT_FRAC = 16;
  localparam int OUT_MAX  = 65535;
  localparam int HASH_W   = 4;

  // register stages from input to result
  localparam int PIPE_DEPTH = 8;

  // fade curve 6t^5 - 15t^4 + 10t^3
  localparam int FADE_A = 6;
  localparam int FADE_B = 15;
  localparam int FADE_C = 10;

  // gradient selection
  localparam logic [HASH_W-1:0] GRAD_SEL_P = 4'd8;
  localparam logic [HASH_W-1:0] GRAD_SEL_Q = 4'd4;
  localparam logic [HASH_W-1:0] GRAD_QX_A  = 4'd12;
  localparam logic [HASH_W-1:0] GRAD_QX_B  = 4'd14;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_t;

endpackage

// ===== hw/rtl/gn3_if.sv =====
`timescale 1ns / 1ps
// gn3_req_if / gn3_res_if: valid/ready channels of the noise sampler.
// Depends on gn3_pkg.

interface gn3_req_if import gn3_pkg::*; ();
  logic                 valid;
  logic                 ready;
  req_t                 req_type;
  logic [BYTE_W-1:0]    table_index;
  logic [BYTE_W-1:0]    table_value;
  logic [COORD_W-1:0]   coord_x;
  logic [COORD_W-1:0]   coord_y;
  logic [COORD_W-1:0]   coord_z;

  modport source (output valid, req_type, table_index, table_value, coord_x, coord_y,
                  coord_z, input ready);
  modport sink   (input valid, req_type, table_index, table_value, coord_x, coord_y,
                  coord_z, output ready);
endinterface

interface gn3_res_if import gn3_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OUT_W-1:0]   noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

// ===== hw/rtl/gn3_lut.sv =====
`timescale 1ns / 1ps
// gn3_lut: one copy of the permutation table, one write and two registered reads.
// Depends on gn3_pkg. Unwritten entries read as the identity permutation.

module gn3_lut import gn3_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
  input  logic [BYTE_W-1:0]             wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(TABLE_SIZE)-1:0] rd_addr0,
  input  logic [$clog2(TABLE_SIZE)-1:0] rd_addr1,
  output logic [BYTE_W-1:0]             rd_data0,
  output logic [BYTE_W-1:0]             rd_data1
);

  logic [BYTE_W-1:0]     mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] vld_r;
  logic [BYTE_W-1:0]     d0_r, d1_r, id0_r, id1_r;
  logic                  h0_r, h1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      d0_r  <= mem[rd_addr0];
      d1_r  <= mem[rd_addr1];
      h0_r  <= vld_r[rd_addr0];
      h1_r  <= vld_r[rd_addr1];
      id0_r <= BYTE_W'(rd_addr0);
      id1_r <= BYTE_W'(rd_addr1);
    end
  end

  assign rd_data0 = h0_r ? d0_r : id0_r;
  assign rd_data1 = h1_r ? d1_r : id1_r;

endmodule

// ===== hw/rtl/gn3_fade.sv =====
`timescale 1ns / 1ps
// gn3_fade: four-stage pipelined quintic fade 6t^5-15t^4+10t^3, clamped to 0..1.
// Depends on gn3_pkg. Stage k loads on en[k].

module gn3_fade import gn3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic [3:0]           en,
  input  logic [FRAC_BITS-1:0] t,
  output logic [FRAC_BITS:0]   u
);

  localparam int FB  = FRAC_BITS;
  localparam int UW  = FB + 1;
  localparam int P1W = 2 * FB;
  localparam int PLW = FB + 5;
  localparam int RPW = UW + PLW;
  localparam int QW  = FB + 7;
  localparam logic [RPW:0]  HALF_W = (RPW + 1)'(1) << (FB - 1);
  localparam logic [QW-1:0] ONE_Q  = QW'(1) << FB;

  logic [FB-1:0]    t1_r;
  logic [P1W-1:0]   p1_r;
  logic [P1W:0]     t3p_r;
  logic [PLW-1:0]   poly_r;
  logic [RPW-1:0]   rp_r;
  logic [UW-1:0]    u_r;

  logic [P1W:0]     s2;
  logic [UW-1:0]    t2;
  logic [PLW:0]     poly;
  logic [P1W+1:0]   s3;
  logic [UW-1:0]    t3;
  logic [RPW:0]     s4;
  logic [QW-1:0]    q4;

  always_comb begin
    s2   = {1'b0, p1_r} + HALF_W[P1W:0];
    t2   = s2[P1W:FB];
    poly = ((PLW + 1)'(FADE_C) << FB)
         + (PLW + 1)'(FADE_A) * (PLW + 1)'(t2)
         - (PLW + 1)'(FADE_B) * (PLW + 1)'(t1_r);
    s3   = {1'b0, t3p_r} + HALF_W[P1W+1:0];
    t3   = s3[P1W:FB];
    s4   = {1'b0, rp_r} + HALF_W;
    q4   = s4[RPW:FB];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t1_r <= t;
      p1_r <= P1W'(t) * P1W'(t);
    end
    if (en[1]) begin
      t3p_r  <= (P1W + 1)'(t2) * (P1W + 1)'(t1_r);
      poly_r <= poly[PLW-1:0];
    end
    if (en[2]) begin
      rp_r <= RPW'(t3) * RPW'(poly_r);
    end
    if (en[3]) begin
      u_r <= (q4 > ONE_Q) ? ONE_Q[UW-1:0] : q4[UW-1:0];
    end
  end

  assign u = u_r;

endmodule

// ===== hw/rtl/gradient_noise_3d_sample.sv =====
`timescale 1ns / 1ps
// gradient_noise_3d_sample: pipelined 3-D improved gradient noise sampler.
// Depends on gn3_pkg, gn3_if, gn3_lut, gn3_fade.
//
//   channel   dir  payload                                              notes
//   in_ch     in   req_type, table_index, table_value, coord_x/y/z     load or sample
//   out_ch    out  noise_value                                          one per sample
//
// One item per cycle unless the output stalls; a sample's result leaves the last stage.
// Latency is set by three dependent permutation lookups and the multiply chains of
// fade and trilinear blend, one multiply per stage. The table is held in seven copies,
// one per read pair; a load writes each copy as it passes that copy's lookup stage.
// Loads leave after stage 3 and give no result. Every stage stalls on its own, so bubbles
// fill while the output waits. Reset clears valid bits and restores the identity table.

module gradient_noise_3d_sample import gn3_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  gn3_req_if.sink   in_ch,
  gn3_res_if.source out_ch
);

  localparam int TW  = $clog2(TABLE_SIZE);
  localparam int FB  = FRAC_BITS;
  localparam int VW  = FB + 5;
  localparam int UW  = FB + 1;
  localparam int PW  = UW + 1 + VW;
  localparam int NS  = PIPE_DEPTH;
  localparam int OW  = VW + 8;
  localparam int SH  = FB + 1 - OUT_FRAC;
  localparam int LSH = (SH < 0) ? -SH : 0;
  localparam int RSH = (SH > 0) ? SH : 0;
  localparam int RND = (RSH > 0) ? (1 << (RSH - 1)) : 0;
  localparam logic signed [VW-1:0] ONE_V  = VW'(1) << FB;
  localparam logic signed [PW-1:0] HALF_P = PW'(1) << (FB - 1);

  function automatic logic signed [VW-1:0] grad_dot(input logic [HASH_W-1:0] h,
                                                     input logic signed [VW-1:0] dx,
                                                     input logic signed [VW-1:0] dy,
                                                     input logic signed [VW-1:0] dz);
    logic signed [VW-1:0] p, q;
    p = (h < GRAD_SEL_P) ? dx : dy;
    if (h < GRAD_SEL_Q) begin
      q = dy;
    end else if (h inside {GRAD_QX_A, GRAD_QX_B}) begin
      q = dx;
    end else begin
      q = dz;
    end
    if (h[0]) p = -p;
    if (h[1]) q = -q;
    return p + q;
  endfunction

  function automatic logic signed [PW-1:0] wmul(input logic [UW-1:0] t,
                                                input logic signed [VW-1:0] d);
    logic signed [PW-1:0] r;
    r = $signed({1'b0, t}) * d;
    return r;
  endfunction

  // divide by 2^FB, round to nearest, ties upward
  function automatic logic signed [VW-1:0] resc(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = (p + HALF_P) >>> FB;
    return VW'(s);
  endfunction

  // pipeline control
  logic [NS:1] v_r;
  logic [NS:1] rdy;
  logic [NS:1] go;
  req_t        kind1_r, kind2_r, kind3_r;

  always_comb begin
    rdy[NS] = !v_r[NS] || out_ch.ready;
    for (int k = NS - 1; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    go[1] = in_ch.valid && rdy[1];
    go[2] = v_r[1] && rdy[2];
    go[3] = v_r[2] && rdy[3];
    go[4] = v_r[3] && (kind3_r == REQ_SAMPLE) && rdy[4];
    for (int k = 5; k <= NS; k++) begin
      go[k] = v_r[k-1] && rdy[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) v_r[1] <= in_ch.valid;
      if (rdy[2]) v_r[2] <= v_r[1];
      if (rdy[3]) v_r[3] <= v_r[2];
      if (rdy[4]) v_r[4] <= v_r[3] && (kind3_r == REQ_SAMPLE);
      for (int k = 5; k <= NS; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_ch.ready = rdy[1];

  // stage 1: first lookup, fractions
  logic [TW-1:0]       ix, iy1_r, iz1_r, idx1_r, idx2_r, iz2_r;
  logic [BYTE_W-1:0]   val1_r, val2_r;
  logic [FB-1:0]       fx1_r, fy1_r, fz1_r, fx2_r, fy2_r, fz2_r, fx3_r, fy3_r, fz3_r;
  logic [BYTE_W-1:0]   la1, lb1;

  assign ix = TW'(in_ch.coord_x >> FB);

  always_ff @(posedge clk) begin
    if (go[1]) begin
      kind1_r <= in_ch.req_type;
      idx1_r  <= TW'(in_ch.table_index);
      val1_r  <= in_ch.table_value;
      fx1_r   <= in_ch.coord_x[FB-1:0];
      fy1_r   <= in_ch.coord_y[FB-1:0];
      fz1_r   <= in_ch.coord_z[FB-1:0];
      iy1_r   <= TW'(in_ch.coord_y >> FB);
      iz1_r   <= TW'(in_ch.coord_z >> FB);
    end
  end

  gn3_lut #(.TABLE_SIZE(TABLE_SIZE)) u_lut1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (go[1] && (in_ch.req_type == REQ_LOAD)),
    .wr_addr  (TW'(in_ch.table_index)),
    .wr_data  (in_ch.table_value),
    .rd_en    (go[1] && (in_ch.req_type == REQ_SAMPLE)),
    .rd_addr0 (ix),
    .rd_addr1 (ix + TW'(1)),
    .rd_data0 (la1),
    .rd_data1 (lb1)
  );

  // stage 2: second lookup
  logic [TW-1:0]     base2 [2];
  logic [BYTE_W-1:0] l2 [4];

  assign base2[0] = TW'(la1) + iy1_r;
  assign base2[1] = TW'(lb1) + iy1_r;

  for (genvar g = 0; g < 2; g++) begin : g_lut2
    gn3_lut #(.TABLE_SIZE(TABLE_SIZE)) u_lut (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (go[2] && (kind1_r == REQ_LOAD)),
      .wr_addr  (idx1_r),
      .wr_data  (val1_r),
      .rd_en    (go[2] && (kind1_r == REQ_SAMPLE)),
      .rd_addr0 (base2[g]),
      .rd_addr1 (base2[g] + TW'(1)),
      .rd_data0 (l2[2*g]),
      .rd_data1 (l2[2*g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (go[2]) begin
      kind2_r <= kind1_r;
      idx2_r  <= idx1_r;
      val2_r  <= val1_r;
      fx2_r   <= fx1_r;
      fy2_r   <= fy1_r;
      fz2_r   <= fz1_r;
      iz2_r   <= iz1_r;
    end
  end

  // stage 3: corner hashes; bases in order aa, ba, ab, bb
  logic [TW-1:0]     base3 [4];
  logic [BYTE_W-1:0] h3 [8];

  assign base3[0] = TW'(l2[0]) + iz2_r;
  assign base3[1] = TW'(l2[2]) + iz2_r;
  assign base3[2] = TW'(l2[1]) + iz2_r;
  assign base3[3] = TW'(l2[3]) + iz2_r;

  for (genvar g = 0; g < 4; g++) begin : g_lut3
    gn3_lut #(.TABLE_SIZE(TABLE_SIZE)) u_lut (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (go[3] && (kind2_r == REQ_LOAD)),
      .wr_addr  (idx2_r),
      .wr_data  (val2_r),
      .rd_en    (go[3] && (kind2_r == REQ_SAMPLE)),
      .rd_addr0 (base3[g]),
      .rd_addr1 (base3[g] + TW'(1)),
      .rd_data0 (h3[2*g]),
      .rd_data1 (h3[2*g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (go[3]) begin
      kind3_r <= kind2_r;
      fx3_r   <= fx2_r;
      fy3_r   <= fy2_r;
      fz3_r   <= fz2_r;
    end
  end

  // fade, in step with stages 1 to 4
  logic [UW-1:0] u4, v4, w4;

  gn3_fade #(.FRAC_BITS(FB)) u_fade_x (
    .clk (clk), .en (go[4:1]), .t (in_ch.coord_x[FB-1:0]), .u (u4)
  );
  gn3_fade #(.FRAC_BITS(FB)) u_fade_y (
    .clk (clk), .en (go[4:1]), .t (in_ch.coord_y[FB-1:0]), .u (v4)
  );
  gn3_fade #(.FRAC_BITS(FB)) u_fade_z (
    .clk (clk), .en (go[4:1]), .t (in_ch.coord_z[FB-1:0]), .u (w4)
  );

  // stage 4: gradient dots; corner i = {y, x, z}
  logic signed [VW-1:0] fxs, fys, fzs, gxs, gys, gzs;
  logic signed [VW-1:0] c_nxt [8];
  logic signed [VW-1:0] c4_r [8];

  always_comb begin
    fxs = VW'(fx3_r);
    fys = VW'(fy3_r);
    fzs = VW'(fz3_r);
    gxs = fxs - ONE_V;
    gys = fys - ONE_V;
    gzs = fzs - ONE_V;
    for (int i = 0; i < 8; i++) begin
      c_nxt[i] = grad_dot(h3[i][HASH_W-1:0],
                          i[1] ? gxs : fxs,
                          i[2] ? gys : fys,
                          i[0] ? gzs : fzs);
    end
  end

  always_ff @(posedge clk) begin
    if (go[4]) begin
      c4_r <= c_nxt;
    end
  end

  // stage 5: x blends; m = {z, y}
  logic signed [PW-1:0] pr5_r [4];
  logic signed [VW-1:0] lo5_r [4];
  logic [UW-1:0]        v5_r, w5_r, w6_r;

  always_ff @(posedge clk) begin
    if (go[5]) begin
      for (int m = 0; m < 4; m++) begin
        pr5_r[m] <= wmul(u4, c4_r[{m[0], 1'b1, m[1]}] - c4_r[{m[0], 1'b0, m[1]}]);
        lo5_r[m] <= c4_r[{m[0], 1'b0, m[1]}];
      end
      v5_r <= v4;
      w5_r <= w4;
    end
  end

  // stage 6: y blends
  logic signed [VW-1:0] x6 [4];
  logic signed [PW-1:0] pr6_r [2];
  logic signed [VW-1:0] lo6_r [2];

  always_comb begin
    for (int m = 0; m < 4; m++) begin
      x6[m] = lo5_r[m] + resc(pr5_r[m]);
    end
  end

  always_ff @(posedge clk) begin
    if (go[6]) begin
      pr6_r[0] <= wmul(v5_r, x6[1] - x6[0]);
      pr6_r[1] <= wmul(v5_r, x6[3] - x6[2]);
      lo6_r[0] <= x6[0];
      lo6_r[1] <= x6[2];
      w6_r     <= w5_r;
    end
  end

  // stage 7: z blend
  logic signed [VW-1:0] y7 [2];
  logic signed [PW-1:0] pr7_r;
  logic signed [VW-1:0] lo7_r;

  always_comb begin
    y7[0] = lo6_r[0] + resc(pr6_r[0]);
    y7[1] = lo6_r[1] + resc(pr6_r[1]);
  end

  always_ff @(posedge clk) begin
    if (go[7]) begin
      pr7_r <= wmul(w6_r, y7[1] - y7[0]);
      lo7_r <= y7[0];
    end
  end

  // stage 8: map to 0..1 and saturate
  logic signed [VW-1:0] val8;
  logic [OW-1:0]        vw8;
  logic [OUT_W-1:0]     noise_nxt, noise_r;

  always_comb begin
    val8 = lo7_r + resc(pr7_r) + ONE_V;
    vw8  = val8[VW-1] ? '0 : {{(OW-VW){1'b0}}, val8};
    vw8  = ((vw8 << LSH) + OW'(RND)) >> RSH;
    noise_nxt = (vw8 > OW'(OUT_MAX)) ? OUT_W'(OUT_MAX) : vw8[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (go[8]) begin
      noise_r <= noise_nxt;
    end
  end

  assign out_ch.valid       = v_r[NS];
  assign out_ch.noise_value = noise_r;

endmodule

// ===== hw/rtl/gn3_chk.sv =====
`timescale 1ns / 1ps
// gn3_chk: port-level checks for gradient_noise_3d_sample, bound to the top level.
// Depends on gn3_pkg.

module gn3_chk import gn3_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input req_t             in_req_type,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] out_noise_value
);

  localparam int CW = $clog2(PIPE_DEPTH + 2);

  logic [CW-1:0] cnt_r;
  logic          smp_in, res_out;

  assign smp_in  = in_valid && in_ready && (in_req_type == REQ_SAMPLE);
  assign res_out = out_valid && out_ready;

  // samples taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + CW'(smp_in) - CW'(res_out);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_noise_value))
    else $error("result changed while stalled");

  a_owned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result without a sample item");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(PIPE_DEPTH))
    else $error("more samples in flight than stages");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind gradient_noise_3d_sample gn3_chk u_gn3_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_req_type     (in_ch.req_type),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_noise_value (out_ch.noise_value)
);
